[sv/bas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_pkg
// Shared widths, types and de Casteljau split helpers for the subdivider.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam int CoordBits     = 16;
    localparam int MaxDepth      = 6;
    localparam int CfgBits       = 3;
    localparam int DataBits      = 32;
    localparam int PaddrBits     = 3;
    localparam int LevelBits     = $clog2(MaxDepth + 1);
    localparam int SpBits        = $clog2(MaxDepth + 1);
    localparam int StackAddrBits = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

    // flatness datapath widths
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * CoordBits + 2;
    localparam int CrossBits = 2 * CoordBits + 3;
    localparam int SumBits   = 2 * CoordBits + 4;
    localparam int RhsBits   = 2 * CoordBits + 1;
    localparam int SqBits    = 2 * CoordBits;

    typedef logic [CoordBits-1:0]       t_coord;
    typedef logic [3:0][CoordBits-1:0]  t_quad;

    typedef struct packed {
        t_quad                 x;
        t_quad                 y;
        logic [LevelBits-1:0]  level;
    } t_entry;

    function automatic t_coord bas_mid(t_coord a, t_coord b);
        logic [CoordBits:0] s;
        s = {a[CoordBits-1], a} + {b[CoordBits-1], b};
        return s[CoordBits:1];
    endfunction

    function automatic t_quad bas_split(t_quad p, logic right_half);
        t_coord l2;
        t_coord h;
        t_coord r3;
        t_coord l3;
        t_coord r2;
        t_coord l4;
        t_quad  q;
        l2 = bas_mid(p[0], p[1]);
        h  = bas_mid(p[1], p[2]);
        r3 = bas_mid(p[2], p[3]);
        l3 = bas_mid(l2, h);
        r2 = bas_mid(r3, h);
        l4 = bas_mid(l3, r2);
        if (right_half) begin
            q[0] = l4;
            q[1] = r2;
            q[2] = r3;
            q[3] = p[3];
        end else begin
            q[0] = p[0];
            q[1] = l2;
            q[2] = l3;
            q[3] = l4;
        end
        return q;
    endfunction

endpackage

[sv/bezier_adaptive_subdivider_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_adaptive_subdivider_core
// Flattens a cubic Bezier curve into segment end points by depth-first
// midpoint subdivision; right halves wait on a RAM-based stack.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_stall  | start, ctrl1, ctrl2, end (x,y)
//  out     | output    | o_out_valid / i_out_stall| point_x, point_y, last_point
//  cfg     | input     | APB psel/penable/pready  | max_level at address 0
//
//  Each segment visit runs through start, the 4-stage flatness pipeline
//  and decide, plus a stack pop read; up to 127 visits per curve.
//  One curve at a time; a new curve is taken once the previous last point
//  has moved into the output register. Synchronous active-low reset, no
//  clearing pass. A stalled output only holds the walk when a new point
//  has to be passed on.
// ----------------------------------------------------------------------------
module bezier_adaptive_subdivider_core
    import bas_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PaddrBits-1:0]        paddr,
    input  logic [DataBits-1:0]         pwdata,
    output logic [DataBits-1:0]         prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [CoordBits-1:0] i_start_x,
    input  logic signed [CoordBits-1:0] i_start_y,
    input  logic signed [CoordBits-1:0] i_ctrl1_x,
    input  logic signed [CoordBits-1:0] i_ctrl1_y,
    input  logic signed [CoordBits-1:0] i_ctrl2_x,
    input  logic signed [CoordBits-1:0] i_ctrl2_y,
    input  logic signed [CoordBits-1:0] i_end_x,
    input  logic signed [CoordBits-1:0] i_end_y,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [CoordBits-1:0] o_point_x,
    output logic signed [CoordBits-1:0] o_point_y,
    output logic                        o_last_point
);

    localparam logic REG_MAX_LEVEL = 1'b0;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TEST   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0]           r_state, n_state;
    t_quad                r_seg_x, n_seg_x, r_seg_y, n_seg_y;
    logic [LevelBits-1:0] r_level, n_level, r_lim, n_lim;
    logic [SpBits-1:0]    r_sp, n_sp, sp_dec;
    logic                 r_flat, n_flat;
    logic                 r_hold_valid, n_hold_valid;
    t_coord               r_hold_x, n_hold_x, r_hold_y, n_hold_y;
    logic                 r_out_valid, n_out_valid;
    t_coord               r_out_x, n_out_x, r_out_y, n_out_y;
    logic                 r_out_last, n_out_last;
    logic [CfgBits-1:0]   r_max_level;

    logic   in_accept, cfg_write, out_free, do_next;
    logic   push_out, push_last;
    logic   flat_start, flat_done, flat_res;
    logic   ram_we, ram_re;
    t_entry wr_entry, rd_entry;
    logic [$bits(t_entry)-1:0] ram_rdata;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready
                        && (paddr[PaddrBits-1:2] == REG_MAX_LEVEL);
    assign prdata     = (paddr[PaddrBits-1:2] == REG_MAX_LEVEL)
                        ? DataBits'(r_max_level) : '0;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign sp_dec     = r_sp - 1'b1;

    assign wr_entry.x     = bas_split(r_seg_x, 1'b1);
    assign wr_entry.y     = bas_split(r_seg_y, 1'b1);
    assign wr_entry.level = r_level + 1'b1;
    assign rd_entry       = t_entry'(ram_rdata);

    always_comb begin
        n_state      = r_state;
        n_seg_x      = r_seg_x;
        n_seg_y      = r_seg_y;
        n_level      = r_level;
        n_lim        = r_lim;
        n_sp         = r_sp;
        n_flat       = r_flat;
        n_hold_valid = r_hold_valid;
        n_hold_x     = r_hold_x;
        n_hold_y     = r_hold_y;
        flat_start   = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        push_out     = 1'b0;
        push_last    = 1'b0;
        do_next      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_seg_x      = {i_end_x, i_ctrl2_x, i_ctrl1_x, i_start_x};
                    n_seg_y      = {i_end_y, i_ctrl2_y, i_ctrl1_y, i_start_y};
                    n_level      = '0;
                    n_sp         = '0;
                    n_hold_valid = 1'b0;
                    n_lim        = (r_max_level > CfgBits'(MaxDepth))
                                   ? LevelBits'(MaxDepth) : LevelBits'(r_max_level);
                    n_state      = S_TEST;
                end
            end
            S_TEST: begin
                flat_start = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (flat_done) begin
                    n_flat  = flat_res;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_flat) begin
                    if (!r_hold_valid || out_free) begin
                        push_out     = r_hold_valid;
                        n_hold_valid = 1'b1;
                        n_hold_x     = r_seg_x[3];
                        n_hold_y     = r_seg_y[3];
                        do_next      = 1'b1;
                    end
                end else if ((r_level < r_lim) && (r_sp < SpBits'(MaxDepth))) begin
                    ram_we  = 1'b1;
                    n_sp    = r_sp + 1'b1;
                    n_seg_x = bas_split(r_seg_x, 1'b0);
                    n_seg_y = bas_split(r_seg_y, 1'b0);
                    n_level = r_level + 1'b1;
                    n_state = S_TEST;
                end else begin
                    do_next = 1'b1;
                end
            end
            S_POP: begin
                n_seg_x = rd_entry.x;
                n_seg_y = rd_entry.y;
                n_level = rd_entry.level;
                n_state = S_TEST;
            end
            S_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push_out     = 1'b1;
                    push_last    = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_next) begin
            if (r_sp == '0) begin
                n_state = S_FLUSH;
            end else begin
                ram_re  = 1'b1;
                n_sp    = sp_dec;
                n_state = S_POP;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        if (push_out) begin
            n_out_valid = 1'b1;
            n_out_x     = r_hold_x;
            n_out_y     = r_hold_y;
            n_out_last  = push_last;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sp         <= '0;
            r_level      <= '0;
            r_lim        <= '0;
            r_flat       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_level  <= CfgBits'(MaxDepth);
        end else begin
            r_state      <= n_state;
            r_sp         <= n_sp;
            r_level      <= n_level;
            r_lim        <= n_lim;
            r_flat       <= n_flat;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            if (cfg_write) begin
                r_max_level <= pwdata[CfgBits-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg_x    <= n_seg_x;
        r_seg_y    <= n_seg_y;
        r_hold_x   <= n_hold_x;
        r_hold_y   <= n_hold_y;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_point_x    = $signed(r_out_x);
    assign o_point_y    = $signed(r_out_y);
    assign o_last_point = r_out_last;

    // push and pop never touch the stack in the same cycle
    bas_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MaxDepth)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sp[StackAddrBits-1:0]),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (sp_dec[StackAddrBits-1:0]),
        .o_rdata (ram_rdata)
    );

    bas_flat u_flat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (flat_start),
        .i_seg_x (r_seg_x),
        .i_seg_y (r_seg_y),
        .o_done  (flat_done),
        .o_flat  (flat_res)
    );

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flat_done |-> (r_state == S_WAIT))
        else $error("flatness result outside wait state");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SpBits'(MaxDepth))
        else $error("stack pointer beyond depth");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("stack push and pop in one cycle");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held point left behind at idle");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_state == S_POP))
        else $error("stack read without pop state");
`endif

endmodule

[sv/bas_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bas_flat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_flat
// Four-stage flatness test: 4*(d2+d3)^2 < dx^2+dy^2, exact products.
// ----------------------------------------------------------------------------
module bas_flat
    import bas_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_quad  i_seg_x,
    input  t_quad  i_seg_y,
    output logic   o_done,
    output logic   o_flat
);

    logic signed [DiffBits-1:0]  dx, dy, a2, b2, a3, b3;
    logic signed [ProdBits-1:0]  r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [CrossBits-1:0] c2, c3;
    logic [CrossBits-1:0]        m2, m3;
    logic [SumBits-1:0]          r_s;
    logic [RhsBits-1:0]          r_rhs, r_rhs2;
    logic                        r_small;
    logic [SqBits-1:0]           r_sq;
    logic                        r_flat;
    logic [3:0]                  r_vld;

    always_comb begin
        dx = DiffBits'($signed(i_seg_x[3])) - DiffBits'($signed(i_seg_x[0]));
        dy = DiffBits'($signed(i_seg_y[3])) - DiffBits'($signed(i_seg_y[0]));
        a2 = DiffBits'($signed(i_seg_x[1])) - DiffBits'($signed(i_seg_x[3]));
        b2 = DiffBits'($signed(i_seg_y[1])) - DiffBits'($signed(i_seg_y[3]));
        a3 = DiffBits'($signed(i_seg_x[2])) - DiffBits'($signed(i_seg_x[3]));
        b3 = DiffBits'($signed(i_seg_y[2])) - DiffBits'($signed(i_seg_y[3]));
    end

    always_comb begin
        c2 = CrossBits'(r_p0) - CrossBits'(r_p1);
        c3 = CrossBits'(r_p2) - CrossBits'(r_p3);
        m2 = c2[CrossBits-1] ? $unsigned(-c2) : $unsigned(c2);
        m3 = c3[CrossBits-1] ? $unsigned(-c3) : $unsigned(c3);
    end

    always_ff @(posedge i_clk) begin
        // stage 1: products
        r_p0 <= a2 * dy;
        r_p1 <= b2 * dx;
        r_p2 <= a3 * dy;
        r_p3 <= b3 * dx;
        r_p4 <= dx * dx;
        r_p5 <= dy * dy;
        // stage 2: distances and chord length
        r_s   <= SumBits'(m2) + SumBits'(m3);
        r_rhs <= r_p4[RhsBits-1:0] + r_p5[RhsBits-1:0];
        // stage 3: square of the distance sum (only small sums can pass)
        r_small <= (r_s[SumBits-1:CoordBits] == '0);
        r_sq    <= r_s[CoordBits-1:0] * r_s[CoordBits-1:0];
        r_rhs2  <= r_rhs;
        // stage 4: compare
        r_flat <= r_small && ({r_sq, 2'b00} < (RhsBits + 1)'(r_rhs2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    assign o_done = r_vld[3];
    assign o_flat = r_flat;

endmodule

[dv/bezier_adaptive_subdivider_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_adaptive_subdivider_core_test
// Self-checking bench for the Bezier flattener. Curves go in through the
// valid/stall input channel; a local de Casteljau walk with exact flatness
// math predicts every emitted point, and each point transaction is checked
// field by field against the oldest prediction. The level limit is swept
// over its full range through the APB port between phases, with random
// input gaps and output stall bursts.
// ----------------------------------------------------------------------------
module bezier_adaptive_subdivider_core_test;
    import bas_pkg::*;

    localparam int CoordMax      = (1 << (CoordBits - 1)) - 1;
    localparam int CoordMin      = -(1 << (CoordBits - 1));
    localparam int SettleCycles  = 1000;
    localparam int WatchdogLimit = 20000;
    localparam int MaxPrinted    = 40;
    localparam logic [PaddrBits-1:0] MaxLevelAddr = '0;

    typedef struct packed {
        t_quad x;
        t_quad y;
    } t_curve;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_point;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PaddrBits-1:0]        paddr;
    logic [DataBits-1:0]         pwdata;
    logic [DataBits-1:0]         prdata;
    logic                        pready;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [CoordBits-1:0] i_start_x;
    logic signed [CoordBits-1:0] i_start_y;
    logic signed [CoordBits-1:0] i_ctrl1_x;
    logic signed [CoordBits-1:0] i_ctrl1_y;
    logic signed [CoordBits-1:0] i_ctrl2_x;
    logic signed [CoordBits-1:0] i_ctrl2_y;
    logic signed [CoordBits-1:0] i_end_x;
    logic signed [CoordBits-1:0] i_end_y;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [CoordBits-1:0] o_point_x;
    logic signed [CoordBits-1:0] o_point_y;
    logic                        o_last_point;

    t_point             expected_points[$];
    t_point             want;
    logic [CfgBits-1:0] max_level_cfg;
    int                 error_count;
    int                 idle_cycles;
    int                 stall_left;
    bit                 idle_en;

    bezier_adaptive_subdivider_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_ctrl1_x    (i_ctrl1_x),
        .i_ctrl1_y    (i_ctrl1_y),
        .i_ctrl2_x    (i_ctrl2_x),
        .i_ctrl2_y    (i_ctrl2_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_last_point (o_last_point)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_error(input string what);
        if (error_count < MaxPrinted) begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
        error_count++;
    endtask

    function automatic void add_expected(t_point p);
        expected_points.insert(expected_points.size(), p);
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic t_coord mid_floor(t_coord a, t_coord b);
        longint s;
        s = longint'($signed(a)) + longint'($signed(b));
        s = s >>> 1;
        return s[CoordBits-1:0];
    endfunction

    function automatic void split_quad(input t_quad p, output t_quad l, output t_quad r);
        t_coord l2;
        t_coord h;
        t_coord r3;
        t_coord l3;
        t_coord r2;
        t_coord l4;
        l2 = mid_floor(p[0], p[1]);
        h  = mid_floor(p[1], p[2]);
        r3 = mid_floor(p[2], p[3]);
        l3 = mid_floor(l2, h);
        r2 = mid_floor(r3, h);
        l4 = mid_floor(l3, r2);
        l[0] = p[0];
        l[1] = l2;
        l[2] = l3;
        l[3] = l4;
        r[0] = l4;
        r[1] = r2;
        r[2] = r3;
        r[3] = p[3];
    endfunction

    function automatic bit segment_is_flat(t_quad x, t_quad y);
        longint          dx;
        longint          dy;
        longint          c2;
        longint          c3;
        longint unsigned s;
        longint unsigned rhs;
        dx = longint'($signed(x[3])) - longint'($signed(x[0]));
        dy = longint'($signed(y[3])) - longint'($signed(y[0]));
        c2 = (longint'($signed(x[1])) - longint'($signed(x[3]))) * dy
             - (longint'($signed(y[1])) - longint'($signed(y[3]))) * dx;
        c3 = (longint'($signed(x[2])) - longint'($signed(x[3]))) * dy
             - (longint'($signed(y[2])) - longint'($signed(y[3]))) * dx;
        if (c2 < 0) c2 = -c2;
        if (c3 < 0) c3 = -c3;
        s = c2 + c3;
        // 4*s^2 beyond 2^62 can never be below the chord length squared
        if (s >= (64'd1 << 30)) return 1'b0;
        rhs = dx * dx + dy * dy;
        return (64'd4 * s * s) < rhs;
    endfunction

    function automatic void flatten_curve(t_curve c);
        t_quad  seg_x;
        t_quad  seg_y;
        t_quad  lx;
        t_quad  ly;
        t_quad  rx;
        t_quad  ry;
        t_quad  stk_x [MaxDepth];
        t_quad  stk_y [MaxDepth];
        int     stk_lvl [MaxDepth];
        int     lvl;
        int     sp;
        int     lim;
        bit     done;
        bit     pop;
        bit     held_valid;
        t_point held;
        seg_x      = c.x;
        seg_y      = c.y;
        lvl        = 0;
        sp         = 0;
        done       = 1'b0;
        held_valid = 1'b0;
        lim        = (max_level_cfg > MaxDepth) ? MaxDepth : max_level_cfg;
        while (!done) begin
            pop = 1'b1;
            if (segment_is_flat(seg_x, seg_y)) begin
                if (held_valid) add_expected(held);
                held.x     = seg_x[3];
                held.y     = seg_y[3];
                held.last  = 1'b0;
                held_valid = 1'b1;
            end else if (lvl < lim && sp < MaxDepth) begin
                split_quad(seg_x, lx, rx);
                split_quad(seg_y, ly, ry);
                stk_x[sp]   = rx;
                stk_y[sp]   = ry;
                stk_lvl[sp] = lvl + 1;
                sp++;
                seg_x = lx;
                seg_y = ly;
                lvl++;
                pop = 1'b0;
            end
            if (pop) begin
                if (sp == 0) begin
                    done = 1'b1;
                end else begin
                    sp--;
                    seg_x = stk_x[sp];
                    seg_y = stk_y[sp];
                    lvl   = stk_lvl[sp];
                end
            end
        end
        if (held_valid) begin
            held.last = 1'b1;
            add_expected(held);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rand_between(int lo, int hi);
        int r;
        r = $urandom_range(0, hi - lo);
        return lo + r;
    endfunction

    function automatic t_coord clamp_coord(int v);
        if (v > CoordMax) v = CoordMax;
        else if (v < CoordMin) v = CoordMin;
        return v[CoordBits-1:0];
    endfunction

    function automatic t_curve make_curve(int sx, int sy, int ax, int ay,
                                          int bx, int by, int ex, int ey);
        t_curve c;
        c.x[0] = clamp_coord(sx);
        c.y[0] = clamp_coord(sy);
        c.x[1] = clamp_coord(ax);
        c.y[1] = clamp_coord(ay);
        c.x[2] = clamp_coord(bx);
        c.y[2] = clamp_coord(by);
        c.x[3] = clamp_coord(ex);
        c.y[3] = clamp_coord(ey);
        return c;
    endfunction

    function automatic t_coord edge_coord();
        case ($urandom_range(0, 4))
            0: return clamp_coord(CoordMin);
            1: return clamp_coord(CoordMax);
            2: return '0;
            3: return '1;
            default: return clamp_coord(rand_between(CoordMin, CoordMax));
        endcase
    endfunction

    function automatic t_curve random_curve();
        t_curve c;
        int     kind;
        int     span;
        int     cx;
        int     cy;
        int     jit;
        int     x0;
        int     y0;
        int     x3;
        int     y3;
        kind = $urandom_range(0, 9);
        cx   = rand_between(CoordMin, CoordMax);
        cy   = rand_between(CoordMin, CoordMax);
        if (kind == 0) begin
            for (int i = 0; i < 4; i++) begin
                c.x[i] = clamp_coord(rand_between(CoordMin, CoordMax));
                c.y[i] = clamp_coord(rand_between(CoordMin, CoordMax));
            end
        end else if (kind == 1) begin
            for (int i = 0; i < 4; i++) begin
                c.x[i] = edge_coord();
                c.y[i] = edge_coord();
            end
        end else if (kind < 9) begin
            span = 1 << ((kind < 6) ? rand_between(2, 9) : rand_between(9, 14));
            for (int i = 0; i < 4; i++) begin
                c.x[i] = clamp_coord(cx + rand_between(-span, span));
                c.y[i] = clamp_coord(cy + rand_between(-span, span));
            end
        end else begin
            // nearly straight: controls close to the chord
            span = 1 << rand_between(3, 13);
            jit  = rand_between(0, 3);
            x0   = cx + rand_between(-span, span);
            y0   = cy + rand_between(-span, span);
            x3   = cx + rand_between(-span, span);
            y3   = cy + rand_between(-span, span);
            c = make_curve(x0, y0,
                           x0 + (x3 - x0) / 3 + rand_between(-jit, jit),
                           y0 + (y3 - y0) / 3 + rand_between(-jit, jit),
                           x0 + 2 * (x3 - x0) / 3 + rand_between(-jit, jit),
                           y0 + 2 * (y3 - y0) / 3 + rand_between(-jit, jit),
                           x3, y3);
        end
        return c;
    endfunction

    task automatic send_curve(input t_curve c);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x  <= c.x[0];
        i_start_y  <= c.y[0];
        i_ctrl1_x  <= c.x[1];
        i_ctrl1_y  <= c.y[1];
        i_ctrl2_x  <= c.x[2];
        i_ctrl2_y  <= c.y[2];
        i_end_x    <= c.x[3];
        i_end_y    <= c.y[3];
        do @(posedge i_clk); while (o_in_stall);
        flatten_curve(c);
    endtask

    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        // a curve with no flat segment may still be walking
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_max_level(input logic [CfgBits-1:0] level);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MaxLevelAddr;
        pwdata  <= DataBits'(level);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        max_level_cfg = level;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CfgBits-1:0] !== level) begin
            report_error($sformatf("max_level readback %0d, wrote %0d",
                                   prdata[CfgBits-1:0], level));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_straight_segments();
        send_curve(make_curve(0, 0, 16, 0, 32, 0, 48, 0));
        send_curve(make_curve(-5, 100, -5, 50, -5, -50, -5, -100));
        send_curve(make_curve(CoordMin, CoordMin, -10000, -10000,
                              10000, 10000, CoordMax, CoordMax));
        send_curve(make_curve(0, 0, -100, 0, 200, 0, 100, 0));
        // zero-length chord: never flat, no points
        send_curve(make_curve(7, 7, 7, 7, 7, 7, 7, 7));
        send_curve(make_curve(CoordMin, CoordMin, CoordMin, CoordMin,
                              CoordMin, CoordMin, CoordMin, CoordMin));
        send_curve(make_curve(CoordMax, CoordMax, CoordMax, CoordMax,
                              CoordMax, CoordMax, CoordMax, CoordMax));
        wait_until_idle();
    endtask

    task automatic test_extreme_hulls();
        send_curve(make_curve(CoordMin, CoordMin, CoordMax, CoordMin,
                              CoordMin, CoordMax, CoordMax, CoordMax));
        send_curve(make_curve(CoordMax, CoordMin, CoordMin, CoordMin,
                              CoordMax, CoordMax, CoordMin, CoordMax));
        send_curve(make_curve(0, 0, CoordMax, CoordMax, CoordMin, CoordMax, 0, 0));
        send_curve(make_curve(-1, -3, -6, -9, -11, -2, -17, -5));
        send_curve(make_curve(0, 0, 0, 160, 160, 160, 160, 0));
        send_curve(make_curve(CoordMin, 0, CoordMax, 1000, CoordMin, 1000, CoordMax, 0));
        wait_until_idle();
    endtask

    task automatic test_level_limits();
        for (int lvl = 0; lvl < (1 << CfgBits); lvl++) begin
            write_max_level(lvl[CfgBits-1:0]);
            send_curve(make_curve(0, 0, 0, 800, 800, 800, 800, 0));
            if (lvl == 0 || lvl == (1 << CfgBits) - 1) begin
                send_curve(make_curve(-1500, -1500, 3000, -1500, -3000, 1500, 1500, 1500));
            end
            wait_until_idle();
        end
    endtask

    task automatic test_random_curves();
        logic [CfgBits-1:0] lvl;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: lvl = CfgBits'(MaxDepth);
                2: lvl = CfgBits'(3);
                3: lvl = '1;
                default: lvl = CfgBits'($urandom_range(0, (1 << CfgBits) - 1));
            endcase
            write_max_level(lvl);
            idle_en = (phase != 2);
            for (int n = 0; n < 54; n++) send_curve(random_curve());
            wait_until_idle();
        end
    endtask

    task automatic test_quiet_tail();
        write_max_level(CfgBits'(MaxDepth));
        idle_en = 1'b0;
        for (int n = 0; n < 35; n++) send_curve(random_curve());
        wait_until_idle();
    endtask

    // ------------------------------------------------------------------
    // output stall, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!idle_en) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                report_error($sformatf("unexpected point (%0d,%0d) last=%0b",
                                       o_point_x, o_point_y, o_last_point));
            end else begin
                want = expected_points.pop_front();
                if (o_point_x !== want.x) begin
                    report_error($sformatf("point_x %0d, expected %0d",
                                           o_point_x, $signed(want.x)));
                end
                if (o_point_y !== want.y) begin
                    report_error($sformatf("point_y %0d, expected %0d",
                                           o_point_y, $signed(want.y)));
                end
                if (o_last_point !== want.last) begin
                    report_error($sformatf("last_point %0b, expected %0b",
                                           o_last_point, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("TIMEOUT: no transaction for %0d cycles", WatchdogLimit);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_start_x     = '0;
        i_start_y     = '0;
        i_ctrl1_x     = '0;
        i_ctrl1_y     = '0;
        i_ctrl2_x     = '0;
        i_ctrl2_y     = '0;
        i_end_x       = '0;
        i_end_y       = '0;
        i_out_stall   = 1'b0;
        max_level_cfg = CfgBits'(MaxDepth);
        error_count   = 0;
        idle_cycles   = 0;
        stall_left    = 0;
        idle_en       = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_straight_segments();
        test_extreme_hulls();
        test_level_limits();
        test_random_curves();
        test_quiet_tail();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bas_pkg.sv
sv/bas_ram.sv
sv/bas_flat.sv
sv/bezier_adaptive_subdivider_core.sv
dv/bezier_adaptive_subdivider_core_test.sv
